// ===== src/lkv_pkg.sv =====
// Shared constants and types for the LRU key/value cache.
package lkv_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int CAP_W       = 5;
    localparam int KEY_W       = 32;
    localparam int DATA_W      = 32;
    localparam int CMP_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(16);
    localparam logic [DATA_W-1:0] MISS_VALUE = {DATA_W{1'b1}};

    typedef enum logic
    {
        REQ_GET = 1'b0,
        REQ_PUT = 1'b1
    } req_type_t;

    typedef logic signed [KEY_W-1:0]  key_t;
    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [IDX_W-1:0]         rank_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic [CAP_W-1:0]         cap_t;

endpackage

// ===== src/lkv_if.sv =====
// Request and response channel interfaces of the LRU key/value cache.
interface lkv_req_if;
    import lkv_pkg::*;

    logic      valid;
    logic      ready;
    req_type_t req_type;
    key_t      key;
    data_t     value;

    modport source (output valid, output req_type, output key, output value, input ready);
    modport sink   (input valid, input req_type, input key, input value, output ready);
endinterface

interface lkv_rsp_if;
    import lkv_pkg::*;

    logic  valid;
    logic  ready;
    logic  found;
    data_t read_value;

    modport source (output valid, output found, output read_value, input ready);
    modport sink   (input valid, input found, input read_value, output ready);
endinterface

// ===== src/lkv_ram.sv =====
// Generic single write port, single read port RAM with registered read.
module lkv_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== src/lru_key_value_cache.sv =====
// LRU key/value cache: top level with scan sequencer, rank file and entry RAM.
// A request runs in order: scan reads of every entry, a drain state, an update state
//   and a response load. The single entry RAM read port is walked once per request, and
//   a new request is accepted only after the previous response is loaded; a waiting
//   response that is not taken holds back that load and so the next request.
// Reset: valid marks, count and control clear at once; capacity resets to 16.
module lru_key_value_cache (
    input  logic                clk,
    input  logic                rst_n,
    lkv_req_if.sink             req,
    lkv_rsp_if.source           rsp,
    input  logic                cfg_we,
    input  logic [lkv_pkg::CAP_W-1:0] cfg_wdata
);
    import lkv_pkg::*;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_UPDATE,
        S_OUT
    } state_t;

    state_t state_reg;

    // latched request
    req_type_t type_reg;
    key_t      key_reg;
    data_t     value_reg;

    // scan pipeline: idx_reg is the address in flight, chk_* the entry whose
    // RAM data is on rdata this cycle
    idx_t idx_reg;
    logic chk_vld_reg;
    idx_t chk_idx_reg;

    // scan results
    logic  hit_found_reg;
    idx_t  hit_idx_reg;
    data_t hit_data_reg;
    logic  old_found_reg;
    idx_t  old_idx_reg;
    rank_t old_rank_reg;
    logic  free_found_reg;
    idx_t  free_idx_reg;

    // cache state kept in flops: valid marks, ages, fill count, capacity
    logic [MAX_ENTRIES-1:0] valid_reg;
    rank_t                  rank_reg [MAX_ENTRIES];
    cnt_t                   count_reg;
    cap_t                   cap_reg;

    // response register
    logic  rsp_valid_reg;
    logic  rsp_found_reg;
    data_t rsp_value_reg;
    logic  res_found_reg;
    data_t res_value_reg;
    logic  rsp_load;

    // entry RAM: {key, data}
    logic                      ram_we;
    idx_t                      ram_waddr;
    logic [KEY_W+DATA_W-1:0]   ram_wdata;
    logic [KEY_W+DATA_W-1:0]   ram_rdata;
    key_t                      rd_key;
    data_t                     rd_data;

    // update decision
    logic [CMP_W-1:0] eff_cap;
    logic [CMP_W-1:0] cap_ext;
    logic             can_fill;
    logic             touch_en;
    logic             fill_en;
    idx_t             slot;
    rank_t            limit;
    logic             all_ages;
    rank_t            rank_next [MAX_ENTRIES];

    lkv_ram #(
        .WIDTH (KEY_W + DATA_W),
        .DEPTH (MAX_ENTRIES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign rd_key  = ram_rdata[KEY_W+DATA_W-1:DATA_W];
    assign rd_data = ram_rdata[DATA_W-1:0];

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = rsp_valid_reg;
    assign rsp.found      = rsp_found_reg;
    assign rsp.read_value = rsp_value_reg;

    // new response goes out when the register is empty or being taken
    assign rsp_load = (state_reg == S_OUT) && (!rsp_valid_reg || rsp.ready);

    // Capacity zero acts as one; above the entry count it saturates.
    assign cap_ext = CMP_W'(cap_reg);
    always_comb
    begin
        priority if (cap_ext == '0)
        begin
            eff_cap = CMP_W'(1);
        end
        else if (cap_ext > CMP_W'(MAX_ENTRIES))
        begin
            eff_cap = CMP_W'(MAX_ENTRIES);
        end
        else
        begin
            eff_cap = cap_ext;
        end
    end
    assign can_fill = (CMP_W'(count_reg) < eff_cap) && free_found_reg;

    // Which entry becomes most recent, and which older entries age by one.
    // A hit ages entries younger than the hit; a fill ages every valid entry;
    // an eviction ages everything younger than the victim.
    always_comb
    begin
        touch_en = 1'b0;
        fill_en  = 1'b0;
        slot     = hit_idx_reg;
        limit    = '0;
        all_ages = 1'b0;
        priority if (hit_found_reg)
        begin
            touch_en = 1'b1;
            slot     = hit_idx_reg;
            limit    = rank_reg[hit_idx_reg];
        end
        else if (type_reg == REQ_PUT && can_fill)
        begin
            touch_en = 1'b1;
            fill_en  = 1'b1;
            slot     = free_idx_reg;
            all_ages = 1'b1;
        end
        else if (type_reg == REQ_PUT && old_found_reg)
        begin
            touch_en = 1'b1;
            slot     = old_idx_reg;
            limit    = old_rank_reg;
        end
        else
        begin
            touch_en = 1'b0;
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            rank_next[i] = rank_reg[i];
            if (idx_t'(i) == slot)
            begin
                rank_next[i] = '0;
            end
            else if (valid_reg[i] && (all_ages || rank_reg[i] < limit))
            begin
                rank_next[i] = rank_reg[i] + 1'b1;
            end
        end
    end

    // RAM is written only in the update state, never while the scan reads it.
    assign ram_we    = (state_reg == S_UPDATE) && (type_reg == REQ_PUT) && touch_en;
    assign ram_waddr = slot;
    assign ram_wdata = {key_reg, value_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            type_reg       <= REQ_GET;
            key_reg        <= '0;
            value_reg      <= '0;
            idx_reg        <= '0;
            chk_vld_reg    <= 1'b0;
            chk_idx_reg    <= '0;
            hit_found_reg  <= 1'b0;
            hit_idx_reg    <= '0;
            hit_data_reg   <= '0;
            old_found_reg  <= 1'b0;
            old_idx_reg    <= '0;
            old_rank_reg   <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            valid_reg      <= '0;
            count_reg      <= '0;
            cap_reg        <= CAP_RESET;
            rsp_valid_reg  <= 1'b0;
            rsp_found_reg  <= 1'b0;
            rsp_value_reg  <= '0;
            res_found_reg  <= 1'b0;
            res_value_reg  <= '0;
        end
        else
        begin
            // capacity only changes while the cache is empty
            if (cfg_we && count_reg == '0)
            begin
                cap_reg <= cfg_wdata;
            end

            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            // compare stage of the scan
            chk_vld_reg <= (state_reg == S_SCAN);
            if (chk_vld_reg)
            begin
                if (valid_reg[chk_idx_reg])
                begin
                    if (!hit_found_reg && rd_key == key_reg)
                    begin
                        hit_found_reg <= 1'b1;
                        hit_idx_reg   <= chk_idx_reg;
                        hit_data_reg  <= rd_data;
                    end
                    if (!old_found_reg || rank_reg[chk_idx_reg] > old_rank_reg)
                    begin
                        old_found_reg <= 1'b1;
                        old_idx_reg   <= chk_idx_reg;
                        old_rank_reg  <= rank_reg[chk_idx_reg];
                    end
                end
                else if (!free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= chk_idx_reg;
                end
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        type_reg       <= req.req_type;
                        key_reg        <= req.key;
                        value_reg      <= req.value;
                        idx_reg        <= '0;
                        hit_found_reg  <= 1'b0;
                        old_found_reg  <= 1'b0;
                        free_found_reg <= 1'b0;
                        state_reg      <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    chk_idx_reg <= idx_reg;
                    if (idx_reg == idx_t'(MAX_ENTRIES - 1))
                    begin
                        state_reg <= S_LAST;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_LAST:
                begin
                    state_reg <= S_UPDATE;
                end
                S_UPDATE:
                begin
                    if (touch_en)
                    begin
                        for (int i = 0; i < MAX_ENTRIES; i++)
                        begin
                            rank_reg[i] <= rank_next[i];
                        end
                    end
                    if (fill_en)
                    begin
                        valid_reg[free_idx_reg] <= 1'b1;
                        count_reg               <= count_reg + 1'b1;
                    end
                    res_found_reg <= hit_found_reg;
                    if (type_reg == REQ_PUT)
                    begin
                        res_value_reg <= '0;
                    end
                    else if (hit_found_reg)
                    begin
                        res_value_reg <= hit_data_reg;
                    end
                    else
                    begin
                        res_value_reg <= MISS_VALUE;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (rsp_load)
                    begin
                        rsp_found_reg <= res_found_reg;
                        rsp_value_reg <= res_value_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

// ===== src/lkv_checker.sv =====
// Port-level assertions for the LRU key/value cache, bound to the top level.
module lkv_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_ready,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic                        rsp_found,
    input logic [lkv_pkg::DATA_W-1:0]  rsp_read_value
);
    import lkv_pkg::*;

    // a held response stays up until taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    // one request at a time: after an accept the request side closes
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while another is in flight");

    // a miss reports either the get miss marker or the put code
    a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_found |->
            (rsp_read_value == MISS_VALUE) || (rsp_read_value == '0))
        else $error("miss response carries a stored value");

    // a new response is only loaded at the end of a request's processing
    a_rsp_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(!req_ready))
        else $error("response appeared without a request in flight");
endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_found      (rsp.found),
    .rsp_read_value (rsp.read_value)
);
